FILE: rtl/core/aocp_pkg.sv
package aocp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DIFF_W    = 17;
    localparam int SUM_W     = 24;
    localparam int SQ_W      = 34;
    localparam int RAD_W     = SQ_W + 16;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int CRD_W     = 28;
    localparam int ANG_W     = 32;
    localparam int PITCH_W   = 16;
    localparam int SQ_CNT_W  = 6;
    localparam int PROD_W    = 49;
    localparam int SCALE_W   = 17;
    localparam int SHIFT_OUT = 30;
    localparam int QDIV_W    = PROD_W - SHIFT_OUT;
    localparam int FIVE_W    = 3;
    localparam int ATAN_IDX_W = 5;

    localparam logic [SCALE_W-1:0]  PITCH_SCALE = 17'd73344;
    localparam logic [PROD_W-1:0]   ROUND_HALF  = 49'd2684354560;
    localparam logic [FIVE_W-1:0]   DIV_FIVE    = 3'd5;
    localparam logic [QDIV_W-1:0]   PITCH_LIMIT = 19'd23042;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_START,
        ST_CAL_DIV,
        ST_SQUARE,
        ST_SQRT_START,
        ST_SQRT,
        ST_CORDIC,
        ST_SCALE,
        ST_DIV5_START,
        ST_DIV5,
        ST_FINISH
    } state_t;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/aocp_div.sv
module aocp_div
    import aocp_pkg::*;
#(
    parameter int DW = 24,
    parameter int VW = 9
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic          done
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, one quotient bit out
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/core/aocp_sqrt.sv
module aocp_sqrt
    import aocp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              done
);

    localparam int CW = $clog2(ROOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ROOT_W+2:0] part;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;

    always_comb
    begin
        part      = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = part - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(ROOT_W);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            // take two radicand bits, settle one root bit
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (part >= trial)
            begin
                rem_next  = diff[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = part[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/aocp_cordic.sv
module aocp_cordic
    import aocp_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [CRD_W-1:0] x0,
    input  logic signed [CRD_W-1:0] y0,
    output logic signed [ANG_W-1:0] angle,
    output logic                    done
);

    localparam int STEP_W = $clog2(STEPS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [STEP_W-1:0]       idx_reg, idx_next;
    logic signed [CRD_W-1:0] x_reg, x_next;
    logic signed [CRD_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    logic signed [ANG_W-1:0] ang;

    always_comb
    begin
        xs        = x_reg >>> idx_reg;
        ys        = y_reg >>> idx_reg;
        ang       = signed'(atan_entry(ATAN_IDX_W'(idx_reg)));
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            x_next    = x0;
            y_next    = y0;
            z_next    = '0;
        end
        else if (busy_reg)
        begin
            // rotate toward y = 0
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - ang;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign angle = z_reg;
    assign done  = done_reg;

endmodule

FILE: rtl/core/accel_offset_calibrate_and_pitch.sv
// Accelerometer offset calibration and pitch. Each beat carries x, y, z and a
// mode bit and yields exactly one result beat. A calibration beat adds the
// sample to running sums; the beat that completes CAL_SAMPLES of them also
// divides the three 24-bit sums by CAL_SAMPLES in bit-serial dividers. A
// measure beat subtracts the offsets and runs the bit-serial units in turn:
// squaring, square root, CORDIC and the divide by five of the degree scaling.
// Pitch is in 1/256 degree, saturated to +/-23042, and 0 when the corrected
// sample is all zero. One beat is in flight at a time; a finished result
// waits in the output register while the next beat is taken.
module accel_offset_calibrate_and_pitch
    import aocp_pkg::*;
#(
    parameter int CAL_SAMPLES  = 100,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic signed [SAMPLE_W-1:0] accel_x,
    input  logic signed [SAMPLE_W-1:0] accel_y,
    input  logic signed [SAMPLE_W-1:0] accel_z,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [PITCH_W-1:0] pitch,
    output logic                      pitch_valid,
    output logic                      calibration_done
);

    localparam int CNT_W = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int DIV_W = $clog2(CAL_SAMPLES + 1);
    localparam logic [DIV_W-1:0] CAL_DIVISOR = DIV_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST    = CNT_W'(CAL_SAMPLES - 1);

    state_t state_reg, state_next;

    logic in_accept;
    logic out_load;

    logic [CNT_W-1:0]        count_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SAMPLE_W-1:0] off_x_reg, off_y_reg, off_z_reg;
    logic                    neg_x_reg, neg_y_reg, neg_z_reg;

    logic signed [DIFF_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0]        mag_y, mag_z;
    logic [SQ_W-1:0]          mcand_reg;
    logic [DIFF_W-1:0]        mplier_reg;
    logic [SQ_W-1:0]          acc_reg;
    logic [SQ_CNT_W-1:0]      sq_cnt_reg;

    logic [ANG_W-1:0]  ang_mag;
    logic              ang_neg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] rounded;

    logic signed [PITCH_W-1:0] res_pitch_reg;
    logic                      res_pv_reg, res_cd_reg;
    logic                      out_valid_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic                      pv_reg, cd_reg;

    logic             cal_start, sqrt_start, cordic_start, div5_start;
    logic [SUM_W-1:0] mag_sx, mag_sy, mag_sz;
    logic [SUM_W-1:0] qx, qy, qz;
    logic             qx_done, qy_done, qz_done;
    logic [ROOT_W-1:0] root;
    logic             sqrt_done;
    logic signed [CRD_W-1:0] cx0, cy0;
    logic signed [ANG_W-1:0] angle;
    logic             cordic_done;
    logic [QDIV_W-1:0] q5;
    logic             q5_done;
    logic [QDIV_W-1:0] q5_sat;
    logic signed [PITCH_W-1:0] q5_pitch;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign dx = DIFF_W'(accel_x) - DIFF_W'(off_x_reg);
    assign dy = DIFF_W'(accel_y) - DIFF_W'(off_y_reg);
    assign dz = DIFF_W'(accel_z) - DIFF_W'(off_z_reg);

    assign mag_y = ry_reg[DIFF_W-1] ? DIFF_W'(-ry_reg) : DIFF_W'(ry_reg);
    assign mag_z = rz_reg[DIFF_W-1] ? DIFF_W'(-rz_reg) : DIFF_W'(rz_reg);

    assign mag_sx = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign mag_sy = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign mag_sz = sum_z_reg[SUM_W-1] ? SUM_W'(-sum_z_reg) : SUM_W'(sum_z_reg);

    assign cx0 = CRD_W'(root);
    assign cy0 = -CRD_W'({{(CRD_W - DIFF_W - 8){rx_reg[DIFF_W-1]}}, rx_reg, 8'h00});

    assign ang_mag = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
    assign rounded = prod_reg + ROUND_HALF;

    assign q5_sat   = (q5 > PITCH_LIMIT) ? PITCH_LIMIT : q5;
    assign q5_pitch = ang_neg_reg ? -PITCH_W'(q5_sat) : PITCH_W'(q5_sat);

    aocp_div #(.DW(SUM_W), .VW(DIV_W)) u_div_x (
        .clk(clk), .rst_n(rst_n), .start(cal_start), .dividend(mag_sx),
        .divisor(CAL_DIVISOR), .quotient(qx), .done(qx_done)
    );
    aocp_div #(.DW(SUM_W), .VW(DIV_W)) u_div_y (
        .clk(clk), .rst_n(rst_n), .start(cal_start), .dividend(mag_sy),
        .divisor(CAL_DIVISOR), .quotient(qy), .done(qy_done)
    );
    aocp_div #(.DW(SUM_W), .VW(DIV_W)) u_div_z (
        .clk(clk), .rst_n(rst_n), .start(cal_start), .dividend(mag_sz),
        .divisor(CAL_DIVISOR), .quotient(qz), .done(qz_done)
    );

    aocp_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .radicand({acc_reg, 16'h0000}), .root(root), .done(sqrt_done)
    );

    aocp_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cordic_start), .x0(cx0), .y0(cy0),
        .angle(angle), .done(cordic_done)
    );

    aocp_div #(.DW(QDIV_W), .VW(FIVE_W)) u_div5 (
        .clk(clk), .rst_n(rst_n), .start(div5_start),
        .dividend(rounded[PROD_W-1:SHIFT_OUT]), .divisor(DIV_FIVE),
        .quotient(q5), .done(q5_done)
    );

    always_comb
    begin
        state_next   = state_reg;
        cal_start    = 1'b0;
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        div5_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode)
                        state_next = (count_reg == CNT_LAST) ? ST_CAL_START : ST_FINISH;
                    else if (dx == '0 && dy == '0 && dz == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_SQUARE;
                end
            end
            ST_CAL_START:
            begin
                cal_start  = 1'b1;
                state_next = ST_CAL_DIV;
            end
            ST_CAL_DIV:
            begin
                if (qx_done && qy_done && qz_done)
                    state_next = ST_FINISH;
            end
            ST_SQUARE:
            begin
                if (sq_cnt_reg == SQ_CNT_W'(2 * DIFF_W - 1))
                    state_next = ST_SQRT_START;
            end
            ST_SQRT_START:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cordic_done)
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DIV5_START;
            end
            ST_DIV5_START:
            begin
                div5_start = 1'b1;
                state_next = ST_DIV5;
            end
            ST_DIV5:
            begin
                if (q5_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_z_reg     <= '0;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            off_z_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (in_accept && mode)
            begin
                sum_x_reg <= sum_x_reg + SUM_W'(accel_x);
                sum_y_reg <= sum_y_reg + SUM_W'(accel_y);
                sum_z_reg <= sum_z_reg + SUM_W'(accel_z);
                count_reg <= (count_reg == CNT_LAST) ? '0 : count_reg + 1'b1;
            end
            else if (state_reg == ST_CAL_DIV && qx_done)
            begin
                off_x_reg <= neg_x_reg ? -SAMPLE_W'(qx) : SAMPLE_W'(qx);
                off_y_reg <= neg_y_reg ? -SAMPLE_W'(qy) : SAMPLE_W'(qy);
                off_z_reg <= neg_z_reg ? -SAMPLE_W'(qz) : SAMPLE_W'(qz);
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cal_start)
        begin
            neg_x_reg <= sum_x_reg[SUM_W-1];
            neg_y_reg <= sum_y_reg[SUM_W-1];
            neg_z_reg <= sum_z_reg[SUM_W-1];
        end

        if (in_accept)
        begin
            rx_reg        <= dx;
            ry_reg        <= dy;
            rz_reg        <= dz;
            res_pitch_reg <= '0;
            res_pv_reg    <= !mode;
            res_cd_reg    <= 1'b0;
            acc_reg       <= '0;
            sq_cnt_reg    <= '0;
        end

        // square |ry| then |rz|, one multiplier bit per cycle
        if (in_accept)
        begin
            mcand_reg  <= SQ_W'(dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy));
            mplier_reg <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        end
        else if (state_reg == ST_SQUARE)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (sq_cnt_reg == SQ_CNT_W'(DIFF_W - 1))
            begin
                mcand_reg  <= SQ_W'(mag_z);
                mplier_reg <= mag_z;
            end
            else
            begin
                mcand_reg  <= {mcand_reg[SQ_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[DIFF_W-1:1]};
            end
        end

        if (state_reg == ST_CAL_DIV)
            res_cd_reg <= 1'b1;

        if (state_reg == ST_SCALE)
        begin
            prod_reg    <= PROD_W'(ang_mag) * PROD_W'(PITCH_SCALE);
            ang_neg_reg <= angle[ANG_W-1];
        end

        if (state_reg == ST_DIV5 && q5_done)
            res_pitch_reg <= q5_pitch;

        if (out_load)
        begin
            pitch_reg <= res_pitch_reg;
            pv_reg    <= res_pv_reg;
            cd_reg    <= res_cd_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pitch            = pitch_reg;
    assign pitch_valid      = pv_reg;
    assign calibration_done = cd_reg;

endmodule
